@@ rtl/core/gsl_pkg.sv @@
// Shared types, constants and a helper function of the glyph sprite layout block.
package gsl_pkg;

   typedef enum logic {
      OP_WIDTH_WRITE = 1'b0,
      OP_CHAR        = 1'b1
   } opcode_type;

   localparam int          TABLE_ENTRIES   = 256;
   localparam int          TABLE_AW        = 8;
   localparam int          GLYPHS_PER_ROW  = 16;
   localparam logic [7:0]  DEFAULT_WIDTH   = 8'd16;
   localparam logic [7:0]  NEWLINE_CODE    = 8'd10;
   localparam logic [1:0]  CSR_DOUBLE_HEIGHT = 2'd0;

   typedef struct packed {
      logic [7:0]         char_code;
      logic               first_of_string;
      logic signed [11:0] origin_x;
      logic signed [11:0] origin_y;
      logic [8:0]         glyph_w;
   } char_type;

   function automatic logic [15:0] screen_edge(input logic [15:0] p);
      logic [11:0] q;
      q = p[11:0] + 12'h800;
      return {q, 4'b0000} - 16'd8;
   endfunction

endpackage

@@ rtl/core/gsl_if.sv @@
// Request and result channel interfaces of the glyph sprite layout block.
interface gsl_req_if;
   logic                   valid;
   logic                   ready;
   gsl_pkg::opcode_type    opcode;
   logic [7:0]             char_code;
   logic [7:0]             width_value;
   logic                   first_of_string;
   logic signed [11:0]     origin_x;
   logic signed [11:0]     origin_y;

   modport source (output valid, opcode, char_code, width_value, first_of_string,
                   origin_x, origin_y, input ready);
   modport sink (input valid, opcode, char_code, width_value, first_of_string,
                 origin_x, origin_y, output ready);
endinterface

interface gsl_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [13:0]     tex_u_start;
   logic [12:0]            tex_v_start;
   logic signed [13:0]     tex_u_end;
   logic [12:0]            tex_v_end;
   logic [15:0]            screen_left;
   logic [15:0]            screen_top;
   logic [15:0]            screen_right;
   logic [15:0]            screen_bottom;

   modport source (output valid, tex_u_start, tex_v_start, tex_u_end, tex_v_end,
                   screen_left, screen_top, screen_right, screen_bottom, input ready);
   modport sink (input valid, tex_u_start, tex_v_start, tex_u_end, tex_v_end,
                 screen_left, screen_top, screen_right, screen_bottom, output ready);
endinterface

@@ rtl/core/gsl_front.sv @@
// Front end: accepts requests, keeps the glyph width table and looks up each width.
module gsl_front (
   input  logic               clock,
   input  logic               reset,
   gsl_req_if.sink            req_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output gsl_pkg::char_type  push_entry
);

   logic [7:0]                          tbl_mem_ff [gsl_pkg::TABLE_ENTRIES];
   logic [gsl_pkg::TABLE_ENTRIES-1:0]   tbl_valid_ff;
   logic [7:0]                          rdata_ff;
   logic                                rd_hit_ff;
   logic                                s1_valid_ff;
   logic [7:0]                          s1_code_ff;
   logic                                s1_first_ff;
   logic signed [11:0]                  s1_ox_ff;
   logic signed [11:0]                  s1_oy_ff;
   logic                                accept;
   logic                                is_char;
   logic [7:0]                          tbl_word;

   assign req_bus.ready = !s1_valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_char       = (req_bus.opcode == gsl_pkg::OP_CHAR);

   always_ff @(posedge clock) begin
      if (accept && !is_char) begin
         tbl_mem_ff[req_bus.char_code] <= req_bus.width_value;
      end
      if (accept && is_char) begin
         rdata_ff    <= tbl_mem_ff[req_bus.char_code];
         s1_code_ff  <= req_bus.char_code;
         s1_first_ff <= req_bus.first_of_string;
         s1_ox_ff    <= req_bus.origin_x;
         s1_oy_ff    <= req_bus.origin_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (accept && !is_char) begin
            tbl_valid_ff[req_bus.char_code] <= 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= is_char;
            if (is_char) begin
               rd_hit_ff <= tbl_valid_ff[req_bus.char_code];
            end
         end else if (push_ready) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   assign tbl_word   = rd_hit_ff ? rdata_ff : gsl_pkg::DEFAULT_WIDTH;
   assign push_valid = s1_valid_ff;

   always_comb begin
      push_entry.char_code       = s1_code_ff;
      push_entry.first_of_string = s1_first_ff;
      push_entry.origin_x        = s1_ox_ff;
      push_entry.origin_y        = s1_oy_ff;
      push_entry.glyph_w         = {1'b0, tbl_word} + {8'b0, tbl_word[0]};
   end

endmodule

@@ rtl/core/gsl_queue.sv @@
// Small first-in first-out queue between the front end and the back end.
module gsl_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  gsl_pkg::char_type  push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output gsl_pkg::char_type  pop_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   gsl_pkg::char_type  slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [CW-1:0]      count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/gsl_back.sv @@
// Back end: tracks the cursor and line, and builds each sprite's corners.
module gsl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               double_height,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  gsl_pkg::char_type  pop_entry,
   gsl_rsp_if.source          rsp_bus
);

   logic [15:0]         cursor_x_ff;
   logic [7:0]          line_count_ff;
   logic                rsp_valid_ff;
   logic signed [13:0]  u0_ff;
   logic [12:0]         v0_ff;
   logic signed [13:0]  u1_ff;
   logic [12:0]         v1_ff;
   logic [15:0]         left_ff;
   logic [15:0]         top_ff;
   logic [15:0]         right_ff;
   logic [15:0]         bottom_ff;

   logic                do_pop;
   logic [15:0]         ox16;
   logic [15:0]         oy16;
   logic [15:0]         cur_base;
   logic [7:0]          line_base;
   logic [7:0]          line_in;
   logic [15:0]         left_p;
   logic [12:0]         line_off;
   logic [5:0]          lh;
   logic [15:0]         top_p;
   logic [15:0]         right_p;
   logic [15:0]         bottom_p;
   logic [9:0]          u_diff;
   logic [13:0]         u0_in;
   logic [13:0]         u1_in;
   logic [12:0]         v0_in;
   logic [12:0]         v1_in;
   logic [4:0]          row_next;

   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      ox16      = {{4{pop_entry.origin_x[11]}}, pop_entry.origin_x};
      oy16      = {{4{pop_entry.origin_y[11]}}, pop_entry.origin_y};
      cur_base  = pop_entry.first_of_string ? ox16 : cursor_x_ff;
      line_base = pop_entry.first_of_string ? 8'd0 : line_count_ff;
      if (pop_entry.char_code == gsl_pkg::NEWLINE_CODE) begin
         line_in = line_base + 8'd1;
         left_p  = ox16;
      end else begin
         line_in = line_base;
         left_p  = cur_base;
      end
      lh       = double_height ? 6'd32 : 6'd16;
      line_off = double_height ? {line_in, 5'b0} : {1'b0, line_in, 4'b0};
      top_p    = oy16 + {3'b0, line_off};
      right_p  = left_p + {7'b0, pop_entry.glyph_w};
      bottom_p = top_p + {10'b0, lh};

      u_diff   = {2'b0, pop_entry.char_code[3:0], 4'b1000}
                 - {2'b0, pop_entry.glyph_w[8:1]};
      u0_in    = {u_diff, 4'b0};
      u1_in    = u0_in + {1'b0, pop_entry.glyph_w, 4'b0};
      v0_in    = {1'b0, pop_entry.char_code[7:4], 8'b0}
                 | (double_height ? 13'd8 : 13'd0);
      row_next = {1'b0, pop_entry.char_code[7:4]} + 5'd1;
      v1_in    = {row_next, 8'b0};
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         u0_ff     <= u0_in;
         v0_ff     <= v0_in;
         u1_ff     <= u1_in;
         v1_ff     <= v1_in;
         left_ff   <= gsl_pkg::screen_edge(left_p);
         top_ff    <= gsl_pkg::screen_edge(top_p);
         right_ff  <= gsl_pkg::screen_edge(right_p);
         bottom_ff <= gsl_pkg::screen_edge(bottom_p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         line_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (do_pop) begin
            cursor_x_ff   <= right_p;
            line_count_ff <= line_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tex_u_start   = u0_ff;
   assign rsp_bus.tex_v_start   = v0_ff;
   assign rsp_bus.tex_u_end     = u1_ff;
   assign rsp_bus.tex_v_end     = v1_ff;
   assign rsp_bus.screen_left   = left_ff;
   assign rsp_bus.screen_top    = top_ff;
   assign rsp_bus.screen_right  = right_ff;
   assign rsp_bus.screen_bottom = bottom_ff;

endmodule

@@ rtl/core/glyph_sprite_layout.sv @@
// Glyph sprite layout top level: width table front end, queue, sprite back end, register.
// A character request passes the front stage register, the queue and the back end registers.
// One request per cycle is sustained while the result channel takes every sprite.
// A width write takes effect for the very next character request.
// Reset clears the table's valid bits at once, so every entry reads 16 until written;
// it also clears the cursor, the line count, the queue and double_height.
module glyph_sprite_layout #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   gsl_req_if.sink      req_bus,
   gsl_rsp_if.source    rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic               double_height_ff;
   logic               push_valid;
   logic               push_ready;
   gsl_pkg::char_type  push_entry;
   logic               pop_valid;
   logic               pop_ready;
   gsl_pkg::char_type  pop_entry;

   assign pready = 1'b1;
   assign prdata = (paddr == gsl_pkg::CSR_DOUBLE_HEIGHT) ? {31'b0, double_height_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         double_height_ff <= 1'b0;
      end else if (psel && penable && pwrite && (paddr == gsl_pkg::CSR_DOUBLE_HEIGHT)) begin
         double_height_ff <= pwdata[0];
      end
   end

   gsl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gsl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   gsl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .double_height (double_height_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_entry     (pop_entry),
      .rsp_bus       (rsp_bus)
   );

endmodule

@@ dv/tb.sv @@
// Testbench of the glyph sprite layout block: a directed table, then random strings.
module tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 3000;

   typedef struct packed {
      gsl_pkg::opcode_type opcode;
      logic [7:0]          char_code;
      logic [7:0]          width_value;
      logic                first_of_string;
      logic signed [11:0]  origin_x;
      logic signed [11:0]  origin_y;
   } glyph_req_type;

   typedef struct packed {
      logic signed [13:0] tex_u_start;
      logic [12:0]        tex_v_start;
      logic signed [13:0] tex_u_end;
      logic [12:0]        tex_v_end;
      logic [15:0]        screen_left;
      logic [15:0]        screen_top;
      logic [15:0]        screen_right;
      logic [15:0]        screen_bottom;
   } sprite_type;

   typedef struct {
      glyph_req_type req;
      bit            typed;
      sprite_type    sprite;
   } table_row_type;

   localparam sprite_type NO_SPRITE = '0;

   bit          clock;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   gsl_req_if req_bus ();
   gsl_rsp_if rsp_bus ();

   glyph_sprite_layout u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [7:0]  glyph_w [gsl_pkg::TABLE_ENTRIES];
   logic [15:0] pen_x;
   logic [7:0]  line_no;
   bit          tall_mode;

   sprite_type    sprite_q [$];
   table_row_type directed_rows [$];
   int         mismatches;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         send_run;
   int         recv_run;
   bit         send_calm;
   bit         recv_calm;
   int         str_left;
   logic signed [11:0] str_ox;
   logic signed [11:0] str_oy;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit stall_roll(int pct, inout int run, inout bit calm);
      if (run == 0) begin
         run = $urandom_range(60, 1);
         calm = ($urandom_range(3) == 0);
      end
      run--;
      return !calm && ($urandom_range(99) < pct);
   endfunction

   function automatic logic [15:0] screen_coord(int p);
      logic [31:0] t;
      t = (p + 2048) * 16 - 8;
      return t[15:0];
   endfunction

   function automatic sprite_type layout_char(glyph_req_type r);
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] left;
      logic [15:0] top;
      logic [8:0]  w;
      int          cx;
      int          u0;
      int          u1;
      int          v0;
      int          v1;
      int          off;
      int          lh;
      sprite_type  s;
      ox = {{4{r.origin_x[11]}}, r.origin_x};
      oy = {{4{r.origin_y[11]}}, r.origin_y};
      if (r.first_of_string) begin
         pen_x = ox;
         line_no = 8'd0;
      end
      if (r.char_code == gsl_pkg::NEWLINE_CODE) begin
         line_no = line_no + 8'd1;
         pen_x = ox;
      end
      off = tall_mode ? 8 : 0;
      lh = tall_mode ? 32 : 16;
      w = {1'b0, glyph_w[r.char_code]};
      if (w[0]) w = w + 9'd1;
      cx = int'(r.char_code[3:0]) * 16 + 8;
      u0 = (cx - int'(w) / 2) * 16;
      u1 = int'(w) * 16 + u0;
      v0 = int'(r.char_code[7:4]) * 256 + off;
      v1 = 256 + v0 - off;
      left = pen_x;
      top = oy + 16'(int'(line_no) * lh);
      s.tex_u_start = u0[13:0];
      s.tex_v_start = v0[12:0];
      s.tex_u_end = u1[13:0];
      s.tex_v_end = v1[12:0];
      s.screen_left = screen_coord(int'(left));
      s.screen_top = screen_coord(int'(top));
      s.screen_right = screen_coord(int'(left) + int'(w));
      s.screen_bottom = screen_coord(int'(top) + lh);
      pen_x = left + 16'(w);
      return s;
   endfunction

   function automatic glyph_req_type mk_req(gsl_pkg::opcode_type op, logic [7:0] code,
                                            logic [7:0] wv, logic first,
                                            logic signed [11:0] ox,
                                            logic signed [11:0] oy);
      glyph_req_type r;
      r.opcode = op;
      r.char_code = code;
      r.width_value = wv;
      r.first_of_string = first;
      r.origin_x = ox;
      r.origin_y = oy;
      return r;
   endfunction

   function automatic logic signed [11:0] pick_origin();
      case ($urandom_range(4))
         0: return 12'sh800;
         1: return 12'sh7FF;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_width();
      case ($urandom_range(9))
         0, 1: return 8'd0;
         2: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic add_row(glyph_req_type r, bit typed, sprite_type s);
      table_row_type row;
      row.req = r;
      row.typed = typed;
      row.sprite = s;
      directed_rows.push_back(row);
   endtask

   task automatic send_req(glyph_req_type r, bit typed, sprite_type s);
      bit         taken;
      sprite_type p;
      while (stall_roll(send_idle_pct, send_run, send_calm)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= r.opcode;
      req_bus.char_code <= r.char_code;
      req_bus.width_value <= r.width_value;
      req_bus.first_of_string <= r.first_of_string;
      req_bus.origin_x <= r.origin_x;
      req_bus.origin_y <= r.origin_y;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end
      if (r.opcode == gsl_pkg::OP_WIDTH_WRITE) begin
         glyph_w[r.char_code] = r.width_value;
      end else begin
         p = layout_char(r);
         sprite_q.push_back(typed ? s : p);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sprite_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      bit done;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= gsl_pkg::CSR_DOUBLE_HEIGHT;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tall_mode = value[0];
   endtask

   task automatic run_random(int count);
      glyph_req_type r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15) begin
            r = glyph_req_type'($urandom);
            r.opcode = gsl_pkg::opcode_type'($urandom_range(1));
            r.origin_x = 12'($urandom);
            r.origin_y = pick_origin();
            r.width_value = 8'($urandom);
         end else if ($urandom_range(99) < 10) begin
            r = mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'($urandom), pick_width(), 1'($urandom),
                       12'($urandom), 12'($urandom));
            if ($urandom_range(2) == 0) r.char_code = 8'($urandom_range(15));
         end else begin
            r = mk_req(gsl_pkg::OP_CHAR, 8'($urandom), 8'($urandom), 1'b0, str_ox, str_oy);
            if (str_left == 0) begin
               str_left = ($urandom_range(19) == 0) ? $urandom_range(300, 100)
                                                    : $urandom_range(24, 1);
               str_ox = pick_origin();
               str_oy = pick_origin();
               r.first_of_string = 1'b1;
               r.origin_x = str_ox;
               r.origin_y = str_oy;
            end
            str_left--;
            case ($urandom_range(19))
               0, 1: r.char_code = gsl_pkg::NEWLINE_CODE;
               2: r.char_code = 8'd0;
               3: r.char_code = 8'd255;
               default: ;
            endcase
         end
         send_req(r, 1'b0, NO_SPRITE);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !stall_roll(recv_idle_pct, recv_run, recv_calm);
   end

   always @(negedge clock) begin
      sprite_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sprite_q.size() == 0) begin
            flag_mismatch("result with no request pending", rsp_bus.screen_left, 16'h0);
         end else begin
            want = sprite_q.pop_front();
            if (rsp_bus.tex_u_start !== want.tex_u_start)
               flag_mismatch("tex_u_start", 16'(rsp_bus.tex_u_start),
                             16'(want.tex_u_start));
            if (rsp_bus.tex_v_start !== want.tex_v_start)
               flag_mismatch("tex_v_start", 16'(rsp_bus.tex_v_start),
                             16'(want.tex_v_start));
            if (rsp_bus.tex_u_end !== want.tex_u_end)
               flag_mismatch("tex_u_end", 16'(rsp_bus.tex_u_end), 16'(want.tex_u_end));
            if (rsp_bus.tex_v_end !== want.tex_v_end)
               flag_mismatch("tex_v_end", 16'(rsp_bus.tex_v_end), 16'(want.tex_v_end));
            if (rsp_bus.screen_left !== want.screen_left)
               flag_mismatch("screen_left", rsp_bus.screen_left, want.screen_left);
            if (rsp_bus.screen_top !== want.screen_top)
               flag_mismatch("screen_top", rsp_bus.screen_top, want.screen_top);
            if (rsp_bus.screen_right !== want.screen_right)
               flag_mismatch("screen_right", rsp_bus.screen_right, want.screen_right);
            if (rsp_bus.screen_bottom !== want.screen_bottom)
               flag_mismatch("screen_bottom", rsp_bus.screen_bottom, want.screen_bottom);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.opcode <= gsl_pkg::OP_WIDTH_WRITE;
      req_bus.char_code <= 8'd0;
      req_bus.width_value <= 8'd0;
      req_bus.first_of_string <= 1'b0;
      req_bus.origin_x <= 12'sd0;
      req_bus.origin_y <= 12'sd0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= gsl_pkg::CSR_DOUBLE_HEIGHT;
      pwdata <= 32'h0;
      for (int i = 0; i < gsl_pkg::TABLE_ENTRIES; i++) glyph_w[i] = gsl_pkg::DEFAULT_WIDTH;
      pen_x = 16'h0;
      line_no = 8'h0;
      tall_mode = 1'b0;
      mismatches = 0;
      str_left = 0;
      send_idle_pct = 10;
      recv_idle_pct = 83;

      // A character with no string start continues from the reset cursor.
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd0, 8'hFF, 1'b0, 12'sh123, 12'sd0), 1'b1,
              '{14'sd0, 13'd0, 14'sd256, 13'd256, 16'h7FF8, 16'h7FF8, 16'h80F8, 16'h80F8});
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd255, 8'hFF, 1'b1, 12'sh800, 12'sh800), 1'b1,
              '{14'sd3840, 13'd3840, 14'sd4096, 13'd4096,
                16'hFFF8, 16'hFFF8, 16'h00F8, 16'h00F8});
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'd0, 8'd255, 1'b1, 12'sh7FF, 12'sh800),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'd1, 8'd0, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'd2, 8'd1, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'd255, 8'd128, 1'b0, 12'sd5, 12'sd5),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd0, 8'h00, 1'b1, 12'sh7FF, 12'sh7FF), 1'b1,
              '{-14'sd1920, 13'd0, 14'sd2176, 13'd256,
                16'hFFE8, 16'hFFE8, 16'h0FE8, 16'h00E8});
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd1, 8'h55, 1'b0, 12'sh7FF, 12'sh7FF),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd2, 8'hAA, 1'b0, 12'sh7FF, 12'sh7FF),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, gsl_pkg::NEWLINE_CODE, 8'h00, 1'b0, 12'sh7FF,
                     12'sh7FF), 1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd255, 8'h00, 1'b0, 12'sh7FF, 12'sh7FF),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, gsl_pkg::NEWLINE_CODE, 8'h00, 1'b1, 12'sd100,
                     -12'sd100), 1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd65, 8'h00, 1'b0, 12'sd100, -12'sd100),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, gsl_pkg::NEWLINE_CODE, 8'd7, 1'b0, 12'sd0,
                     12'sd0), 1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, gsl_pkg::NEWLINE_CODE, 8'h00, 1'b0, 12'sd100,
                     -12'sd100), 1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'd0, 8'h00, 1'b1, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'h0F, 8'h00, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'hF0, 8'h00, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_WIDTH_WRITE, 8'hF0, 8'd255, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);
      add_row(mk_req(gsl_pkg::OP_CHAR, 8'hF0, 8'h00, 1'b0, 12'sd0, 12'sd0),
              1'b0, NO_SPRITE);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(32'h0000_0000);
      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].sprite);
      run_random(400);
      settle();

      csr_write(32'hFFFF_FFFF);
      send_idle_pct = 83;
      recv_idle_pct = 10;
      run_random(400);
      settle();

      csr_write(32'hFFFF_FFFE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(200);
      settle();

      csr_write(32'h0000_0001);
      run_random(200);
      settle();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
